// File: hw/rtl/mandelbrot_escape_time_pixel_assert.svh
// Assertion macros for the escape-time pixel engine.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH

// Same-cycle implication
`define METP_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication
`define METP_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/metp_pkg.sv
// Package for the escape-time pixel engine: constants, register codes and states.
// No dependencies.
`timescale 1ns / 1ps

package metp_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 26;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ITER_W     = 8;
  localparam int unsigned HUE_W      = 8;

  localparam int unsigned HUE_SCALE  = 255;
  localparam int unsigned ESCAPE_SQ  = 4;
  localparam int unsigned DIV_STEPS  = 2 * ITER_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_START  = 3'd0,
    REG_X_STEP   = 3'd1,
    REG_Y_START  = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4,
    REG_HUE_OFF  = 3'd5
  } metp_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_CYW,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_UPD,
    ST_HUE,
    ST_DIV,
    ST_FIN
  } metp_state_e;

endpackage

// File: hw/rtl/metp_pix_if.sv
// Input channel of the escape-time pixel engine: one pixel coordinate per transaction.
// Depends on metp_pkg for the default coordinate width.
`timescale 1ns / 1ps

interface metp_pix_if #(
  parameter int unsigned COORD_BITS = metp_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;

  modport source (output valid, px, py, input ready);
  modport sink   (input valid, px, py, output ready);
endinterface

// File: hw/rtl/metp_res_if.sv
// Output channel of the escape-time pixel engine: one result per transaction.
// Depends on metp_pkg for widths.
`timescale 1ns / 1ps

interface metp_res_if #(
  parameter int unsigned COORD_BITS = metp_pkg::COORD_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [COORD_BITS-1:0]            out_px;
  logic [COORD_BITS-1:0]            out_py;
  logic [metp_pkg::ITER_W-1:0]      iterations;
  logic                             inside_res;
  logic [metp_pkg::HUE_W-1:0]       hue;

  modport source (output valid, out_px, out_py, iterations, inside_res, hue, input ready);
  modport sink   (input valid, out_px, out_py, iterations, inside_res, hue, output ready);
endinterface

// File: hw/rtl/mandelbrot_escape_time_pixel.sv
// Mandelbrot escape-time pixel engine (top level).
// Channels: pix_i takes one (px, py) per transaction; res_o returns one result per
// pixel (coordinates echoed, escape count, inside flag, hue). Viewport, limit and hue
// offset sit in six registers on the plain write port cfg_we_i / cfg_idx_i / cfg_wdata_i;
// write them only while no pixel is in flight.
// An escaping pixel's count is scaled by the divider before its result appears on
// res_o; an inside pixel skips the divider.
// The engine has a single 32x32 signed multiplier, which forms x*x, y*y and x*y one
// after another in each iteration, and a bit-serial divider that scales the count
// to a hue.
// pix_i.ready is high only while the engine is idle, so pixels are worked one at a time.
// The result sits in an output register; a new pixel is taken while it waits. If the
// receiver is still stalled when the next result is ready, the engine holds it back.
// Reset clears the registers to their defaults (limit 255, all else zero), the largest
// count seen and the output valid. No clearing pass is needed.
// Fixed point: signed, FRAC_BITS fraction bits in 32-bit words; products truncated
// toward minus infinity, iterates saturated to the 32-bit range.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pixel_assert.svh"

module mandelbrot_escape_time_pixel #(
  parameter int unsigned COORD_BITS = metp_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = metp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [metp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [metp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  metp_pix_if.sink                         pix_i,
  metp_res_if.source                       res_o
);
  import metp_pkg::*;

  // Widths of the shifted squares and of the update sums
  localparam int unsigned SQ_W = 2 * WORD_W - FRAC_BITS;
  localparam int unsigned WW   = SQ_W + 2;
  localparam logic signed [SQ_W:0] ESC_LIM = (SQ_W + 1)'(ESCAPE_SQ) << FRAC_BITS;

  // Configuration registers
  logic [WORD_W-1:0] x_start_q, x_step_q, y_start_q, y_step_q;
  logic [ITER_W-1:0] max_iter_q;
  logic [HUE_W-1:0]  hue_off_q;

  // Sequencer and datapath
  metp_state_e              state_q, state_d;
  logic [COORD_BITS-1:0]    px_q, px_d, py_q, py_d;
  logic signed [WORD_W-1:0] mul_a, mul_b;
  logic signed [2*WORD_W-1:0] prod, p_q;
  logic signed [WORD_W-1:0] cx_q, cx_d, cy_q, cy_d, x_q, x_d, y_q, y_d;
  logic signed [SQ_W-1:0]   xx_q, xx_d, yy_q, yy_d, yy_w;
  logic signed [SQ_W:0]     mag_sq, two_xy;
  logic signed [WW-1:0]     nx_w, ny_w;
  logic [ITER_W-1:0]        iter_q, iter_d;
  logic [ITER_W-1:0]        max_seen_q, max_seen_d, ms_grow;
  logic                     inside_q, inside_d, inside_w;

  // Bit-serial restoring divider for the hue scaling
  logic [2*ITER_W-1:0]      dq_q, dq_d;
  logic [ITER_W-1:0]        rem_q, rem_d, dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [ITER_W:0]          div_t, div_diff;
  logic                     div_ge;

  // Output register
  logic                     vld_q, vld_d, out_load;
  logic [COORD_BITS-1:0]    o_px_q, o_py_q;
  logic [ITER_W-1:0]        o_iter_q;
  logic                     o_inside_q;
  logic [HUE_W-1:0]         o_hue_q;

  // The one shared multiplier
  assign prod = mul_a * mul_b;

  // Saturate a wide sum to the 32-bit signed range
  function automatic logic signed [WORD_W-1:0] sat_word(logic signed [WW-1:0] v);
    logic hi_all, hi_none;
    hi_all  = &v[WW-1:WORD_W-1];
    hi_none = ~(|v[WW-1:WORD_W-1]);
    if (hi_all || hi_none) begin
      return v[WORD_W-1:0];
    end else if (v[WW-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  assign yy_w   = $signed(p_q[2*WORD_W-1:FRAC_BITS]);
  assign two_xy = $signed(p_q[2*WORD_W-1:FRAC_BITS-1]);
  assign mag_sq = (SQ_W + 1)'(xx_q) + (SQ_W + 1)'(yy_w);
  assign nx_w   = WW'(xx_q) - WW'(yy_q) + WW'(cx_q);
  assign ny_w   = WW'(two_xy) + WW'(cy_q);

  assign ms_grow  = (iter_q > max_seen_q) ? iter_q : max_seen_q;
  assign inside_w = (iter_q == max_iter_q);

  assign div_t    = {rem_q, dq_q[2*ITER_W-1]};
  assign div_diff = div_t - {1'b0, dvs_q};
  assign div_ge   = (div_t >= {1'b0, dvs_q});

  assign out_load    = (state_q == ST_FIN) && (!vld_q || res_o.ready);
  assign pix_i.ready = (state_q == ST_IDLE);

  assign res_o.valid      = vld_q;
  assign res_o.out_px     = o_px_q;
  assign res_o.out_py     = o_py_q;
  assign res_o.iterations = o_iter_q;
  assign res_o.inside_res = o_inside_q;
  assign res_o.hue        = o_hue_q;

  always_comb begin
    state_d    = state_q;
    px_d       = px_q;
    py_d       = py_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    x_d        = x_q;
    y_d        = y_q;
    xx_d       = xx_q;
    yy_d       = yy_q;
    iter_d     = iter_q;
    max_seen_d = max_seen_q;
    inside_d   = inside_q;
    dq_d       = dq_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    cnt_d      = cnt_q;
    vld_d      = vld_q;
    mul_a      = x_q;
    mul_b      = x_q;

    if (vld_q && res_o.ready) begin
      vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pix_i.valid) begin
          px_d    = pix_i.px;
          py_d    = pix_i.py;
          state_d = ST_CX;
        end
      end
      ST_CX: begin
        mul_a   = $signed(WORD_W'(px_q));
        mul_b   = $signed(x_step_q);
        state_d = ST_CY;
      end
      ST_CY: begin
        // column offset wraps modulo 2^32
        cx_d    = $signed(x_start_q + p_q[WORD_W-1:0]);
        mul_a   = $signed(WORD_W'(py_q));
        mul_b   = $signed(y_step_q);
        state_d = ST_CYW;
      end
      ST_CYW: begin
        cy_d    = $signed(y_start_q + p_q[WORD_W-1:0]);
        x_d     = '0;
        y_d     = '0;
        iter_d  = '0;
        state_d = ST_XX;
      end
      ST_XX: begin
        mul_a   = x_q;
        mul_b   = x_q;
        state_d = ST_YY;
      end
      ST_YY: begin
        xx_d    = $signed(p_q[2*WORD_W-1:FRAC_BITS]);
        mul_a   = y_q;
        mul_b   = y_q;
        state_d = ST_XY;
      end
      ST_XY: begin
        yy_d  = yy_w;
        mul_a = x_q;
        mul_b = y_q;
        if ((mag_sq > ESC_LIM) || (iter_q >= max_iter_q)) begin
          state_d = ST_HUE;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        x_d     = sat_word(nx_w);
        y_d     = sat_word(ny_w);
        iter_d  = iter_q + ITER_W'(1);
        state_d = ST_XX;
      end
      ST_HUE: begin
        inside_d = inside_w;
        if (!inside_w && (ms_grow == '0)) begin
          max_seen_d = ITER_W'(1);
          dvs_d      = ITER_W'(1);
        end else begin
          max_seen_d = ms_grow;
          dvs_d      = ms_grow;
        end
        dq_d  = (2 * ITER_W)'(iter_q) * (2 * ITER_W)'(HUE_SCALE);
        rem_d = '0;
        cnt_d = '0;
        state_d = inside_w ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        rem_d = div_ge ? div_diff[ITER_W-1:0] : div_t[ITER_W-1:0];
        dq_d  = {dq_q[2*ITER_W-2:0], div_ge};
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          vld_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vld_q      <= 1'b0;
      max_seen_q <= '0;
      iter_q     <= '0;
      cnt_q      <= '0;
      x_start_q  <= '0;
      x_step_q   <= '0;
      y_start_q  <= '0;
      y_step_q   <= '0;
      max_iter_q <= MAX_ITER_RST;
      hue_off_q  <= '0;
    end else begin
      state_q    <= state_d;
      vld_q      <= vld_d;
      max_seen_q <= max_seen_d;
      iter_q     <= iter_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        unique case (metp_reg_e'(cfg_idx_i))
          REG_X_START:  x_start_q  <= cfg_wdata_i[WORD_W-1:0];
          REG_X_STEP:   x_step_q   <= cfg_wdata_i[WORD_W-1:0];
          REG_Y_START:  y_start_q  <= cfg_wdata_i[WORD_W-1:0];
          REG_Y_STEP:   y_step_q   <= cfg_wdata_i[WORD_W-1:0];
          REG_MAX_ITER: max_iter_q <= cfg_wdata_i[ITER_W-1:0];
          REG_HUE_OFF:  hue_off_q  <= cfg_wdata_i[HUE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    p_q      <= prod;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    x_q      <= x_d;
    y_q      <= y_d;
    xx_q     <= xx_d;
    yy_q     <= yy_d;
    inside_q <= inside_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    if (out_load) begin
      o_px_q     <= px_q;
      o_py_q     <= py_q;
      o_iter_q   <= iter_q;
      o_inside_q <= inside_q;
      o_hue_q    <= inside_q ? '0 : (dq_q[HUE_W-1:0] + hue_off_q);
    end
  end

  // Checks
  `METP_ASSERT_IMP(a_iter_le_limit, state_q == ST_XY, iter_q <= max_iter_q, "count past limit")
  `METP_ASSERT_NXT(a_max_seen_mono, 1'b1, max_seen_q >= $past(max_seen_q), "max_seen fell")
  `METP_ASSERT_IMP(a_quot_fits, (state_q == ST_FIN) && !inside_q, dq_q[2*ITER_W-1:HUE_W] == '0, "hue quotient overflow")
  `METP_ASSERT_NXT(a_accept_starts, pix_i.valid && pix_i.ready, state_q == ST_CX, "accept did not start work")

endmodule

// File: test/mandelbrot_escape_time_pixel_test.sv
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
// Depends on metp_pkg, metp_pix_if, metp_res_if and mandelbrot_escape_time_pixel.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_test;
  import metp_pkg::*;

  localparam int unsigned COORD_W = COORD_BITS_DEF;
  localparam int unsigned FRAC    = FRAC_BITS_DEF;

  // Escape radius squared in fixed point, and the 32-bit signed bounds
  localparam longint ESC_LIMIT = longint'(ESCAPE_SQ) << FRAC;
  localparam longint S32_MAX   = longint'(signed'(32'h7FFF_FFFF));
  localparam longint S32_MIN   = longint'(signed'(32'h8000_0000));

  // Handy viewport values, Q6.26
  localparam logic [31:0] STD_X0   = 32'hF700_0000;  // -2.25
  localparam logic [31:0] STD_Y0   = 32'hFA00_0000;  // -1.5
  localparam logic [31:0] STD_STEP = 32'h0003_0000;  // 3/1024

  localparam int PHASE_ITEMS    = 179;
  localparam int TAIL_CYCLES    = 1100;   // worst-case pixel latency plus margin
  localparam int WATCHDOG_LIMIT = 10000;  // cycles without any transaction

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ITER_W-1:0]  iterations;
    logic               in_set;
    logic [HUE_W-1:0]   hue;
  } pix_outcome_t;

  logic clk;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  metp_pix_if #(.COORD_BITS(COORD_W)) pix_ch ();
  metp_res_if #(.COORD_BITS(COORD_W)) res_ch ();

  mandelbrot_escape_time_pixel #(
    .COORD_BITS (COORD_W),
    .FRAC_BITS  (FRAC)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_ch),
    .res_o       (res_ch)
  );

  // Shadow of the engine's registers and of the largest count seen
  logic [31:0]       vp_x_start, vp_x_step, vp_y_start, vp_y_step;
  logic [ITER_W-1:0] iter_limit;
  logic [HUE_W-1:0]  vp_hue_off;
  int unsigned       peak_count = 0;

  pixel_t       pixel_backlog[$];  // pixels waiting to be sent
  pix_outcome_t pix_outcomes[$];   // predicted results, oldest first
  pixel_t       next_pixel;
  pix_outcome_t want;

  int  mismatches = 0;
  int  send_gap;
  int  stall_left;
  int  stall_draw;
  int  quiet_cycles;
  bit  calm;     // no idling on either side while set
  bit  hold_tx;  // sender holds off new transactions while set

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Escape count, inside flag and hue of one pixel; updates the peak count.
  function automatic pix_outcome_t escape_pixel(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row);
    logic [31:0]  cx_w, cy_w;
    longint       cx, cy, x, y, xx, yy, txy;
    int unsigned  n, hue_sum;
    pix_outcome_t r;
    // c wraps modulo 2^32 before being read as two's complement
    cx_w = vp_x_start + 32'(col) * vp_x_step;
    cy_w = vp_y_start + 32'(row) * vp_y_step;
    cx = longint'(signed'(cx_w));
    cy = longint'(signed'(cy_w));
    x = 0; y = 0; xx = 0; yy = 0; n = 0;
    while (xx + yy <= ESC_LIMIT && n < iter_limit) begin
      txy = (x * y) >>> (FRAC - 1);   // 2xy, floored
      x = clamp32(xx - yy + cx);
      y = clamp32(txy + cy);
      n++;
      xx = (x * x) >>> FRAC;
      yy = (y * y) >>> FRAC;
    end
    if (n > peak_count) peak_count = n;
    r.px = col;
    r.py = row;
    r.iterations = ITER_W'(n);
    r.in_set = (n == iter_limit);
    r.hue = '0;     // inside pixels are drawn black
    if (!r.in_set) begin
      if (peak_count == 0) peak_count = 1;
      hue_sum = (n * HUE_SCALE) / peak_count + vp_hue_off;
      r.hue = HUE_W'(hue_sum);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and idling
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly back to back, often short gaps, now and then a long one
  function automatic int idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: pulls from the backlog, random gap after each transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
      pix_ch.px    <= '0;
      pix_ch.py    <= '0;
      send_gap     <= 0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (send_gap != 0) begin
        pix_ch.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (pixel_backlog.size() != 0 && !hold_tx) begin
        next_pixel    = pixel_backlog.pop_front();
        pix_ch.valid <= 1'b1;
        pix_ch.px    <= next_pixel.px;
        pix_ch.py    <= next_pixel.py;
        send_gap     <= idle_len();
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      stall_draw    = idle_len();
      res_ch.ready <= (stall_draw == 0);
      stall_left   <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------------
  // Accepted pixel: predict its result now, with the registers as they stand
  always @(posedge clk) begin
    if (rst_n && pix_ch.valid && pix_ch.ready)
      pix_outcomes.push_back(escape_pixel(pix_ch.px, pix_ch.py));
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pix_outcomes.size() == 0) begin
        $error("result transaction with no pixel outstanding");
        mismatches++;
      end else begin
        want = pix_outcomes.pop_front();
        check_field("out_px", want.px, res_ch.out_px);
        check_field("out_py", want.py, res_ch.out_py);
        check_field("iterations", want.iterations, res_ch.iterations);
        check_field("inside_res", want.in_set, res_ch.inside_res);
        check_field("hue", want.hue, res_ch.hue);
      end
    end
  end

  // Ends the run if the engine stops moving transactions
  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Waits until every pixel is sent and every result is back (engine idle)
  task automatic drain();
    while (pixel_backlog.size() != 0 || pix_ch.valid || pix_outcomes.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input metp_reg_e idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_X_START:  vp_x_start = val;
      REG_X_STEP:   vp_x_step  = val;
      REG_Y_START:  vp_y_start = val;
      REG_Y_STEP:   vp_y_step  = val;
      REG_MAX_ITER: iter_limit = val[ITER_W-1:0];
      REG_HUE_OFF:  vp_hue_off = val[HUE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reprogram the viewport, limit and hue offset once the engine has gone idle
  task automatic program_engine(input logic [31:0] xs, input logic [31:0] xst,
                                input logic [31:0] ys, input logic [31:0] yst,
                                input logic [7:0] lim, input logic [7:0] hoff);
    drain();
    write_reg(REG_X_START, xs);
    write_reg(REG_X_STEP, xst);
    write_reg(REG_Y_START, ys);
    write_reg(REG_Y_STEP, yst);
    write_reg(REG_MAX_ITER, {24'd0, lim});
    write_reg(REG_HUE_OFF, {24'd0, hoff});
    @(negedge clk);
  endtask

  task automatic send(input int unsigned col, input int unsigned row);
    pixel_backlog.push_back('{px: COORD_W'(col), py: COORD_W'(row)});
  endtask

  // Mostly uniform, with extra weight on both edges of the range
  function automatic int unsigned rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, (1 << COORD_W) - 1);
    if (r < 85) return $urandom_range(0, 7);
    return $urandom_range((1 << COORD_W) - 8, (1 << COORD_W) - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Everything known from time zero; reset held low, then released on a clock edge
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_X_START;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_tx      = 1'b0;
    vp_x_start   = '0;
    vp_x_step    = '0;
    vp_y_start   = '0;
    vp_y_step    = '0;
    iter_limit   = MAX_ITER_RST;
    vp_hue_off   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Limits start low so the peak count grows gradually and
    // the hue division stays non-trivial for a while.

    // Register extremes, c wraps round 2^32; limit 1 puts every pixel inside
    program_engine(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1, 8'd255);
    send(0, 0);
    send(1, 1);
    send(1023, 1023);
    send(2, 3);

    // Unit step along x: c = 0 and c = 1 stay inside, c = 3 escapes at once,
    // px = 1023 wraps to c = -1. Offset pushes the hue past 256.
    program_engine(32'h0, 32'h0400_0000, 32'h0, 32'h0, 8'd2, 8'd200);
    send(0, 0);
    send(1, 5);
    send(3, 0);
    send(1023, 1023);

    // Standard viewport: corners, points on the real axis inside and outside
    // the set, the main cardioid's neck and alternating bit patterns
    program_engine(STD_X0, STD_STEP, STD_Y0, STD_STEP, 8'd40, 8'd0);
    send(0, 0);
    send(1023, 1023);
    send(0, 1023);
    send(1023, 0);
    send(683, 512);
    send(512, 512);
    send(256, 512);
    send(0, 512);
    send(10'h2AA, 10'h155);
    send(10'h155, 10'h2AA);

    // Random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_engine(STD_X0, STD_STEP, STD_Y0, STD_STEP,
                          8'($urandom_range(8, 40)), 8'($urandom_range(0, 255)));
        1: program_engine($urandom, $urandom, $urandom, $urandom,
                          8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
        // Steps running backwards from the top right corner
        2: program_engine(32'h0300_0000, 32'hFFFD_0000, 32'h0600_0000, 32'hFFFD_0000,
                          8'd100, 8'd128);
        // Zoom on the join of the cardioid and the period-two bulb
        3: program_engine(32'hFC00_0000, 32'h0000_4000, 32'hFF80_0000, 32'h0000_4000,
                          8'd64, 8'd255);
        4: program_engine(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          8'd1, 8'd0);
        5: program_engine(STD_X0, STD_STEP, STD_Y0, STD_STEP,
                          8'd255, 8'($urandom_range(0, 255)));
        // Seahorse valley: long, irregular escape counts
        6: program_engine(32'hFCF5_C290, 32'h0000_1000, 32'h0033_3333, 32'h0000_1000,
                          8'd200, 8'($urandom_range(0, 255)));
        default: program_engine($urandom, $urandom, $urandom, $urandom,
                                8'd255, 8'($urandom_range(0, 255)));
      endcase
      calm = (p == 0 || p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send(rand_coord(), rand_coord());
      if (p == 3) begin
        // Sender holds off mid-phase until the engine has emptied out
        while (pixel_backlog.size() > PHASE_ITEMS / 2) @(negedge clk);
        hold_tx = 1'b1;
        while (pix_ch.valid || pix_outcomes.size() != 0) @(negedge clk);
        hold_tx = 1'b0;
      end
    end

    drain();
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/metp_pkg.sv
hw/rtl/metp_pix_if.sv
hw/rtl/metp_res_if.sv
hw/rtl/mandelbrot_escape_time_pixel.sv
test/mandelbrot_escape_time_pixel_test.sv
